>>> design/stlp_pkg.sv
// ----------------------------------------------------------------------------
// stlp_pkg : shared types and constants for the timing line parser
// Character classes, token and result records, parse phases, time scales.
// ----------------------------------------------------------------------------
package stlp_pkg;

    localparam int unsigned TIME_W      = 39;
    localparam int unsigned MS_PER_HOUR = 3600000;
    localparam int unsigned MS_PER_MIN  = 60000;
    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned MS_LIMIT    = 1000;
    localparam int unsigned MIN_LIMIT   = 60;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_GT    = 8'd62;

    typedef enum logic [2:0] {
        CL_DIGIT,
        CL_COLON,
        CL_SEP,
        CL_BLANK,
        CL_DASH,
        CL_GT,
        CL_BREAK,
        CL_OTHER
    } char_class_t;

    typedef struct packed {
        logic        done;
        char_class_t cls;
        logic [3:0]  digit;
    } token_t;

    typedef struct packed {
        logic              ok;
        logic [TIME_W-1:0] begin_ms;
        logic [TIME_W-1:0] finish_ms;
    } result_t;

    typedef enum logic [13:0] {
        PH_LEAD1 = 14'b00000000000001,
        PH_H1    = 14'b00000000000010,
        PH_M1    = 14'b00000000000100,
        PH_S1    = 14'b00000000001000,
        PH_MS1   = 14'b00000000010000,
        PH_GAP1  = 14'b00000000100000,
        PH_DASH1 = 14'b00000001000000,
        PH_DASH2 = 14'b00000010000000,
        PH_LEAD2 = 14'b00000100000000,
        PH_H2    = 14'b00001000000000,
        PH_M2    = 14'b00010000000000,
        PH_S2    = 14'b00100000000000,
        PH_MS2   = 14'b01000000000000,
        PH_TRAIL = 14'b10000000000000
    } phase_t;

endpackage

>>> design/stlp_fifo.sv
// ----------------------------------------------------------------------------
// stlp_fifo : small flop-based first-in first-out queue
// Registered storage, head shown combinationally while not empty.
// ----------------------------------------------------------------------------
module stlp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fifo count beyond depth");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> !empty)
        else $error("fifo empty after a lone write");

    a_read_frees: assert property (@(posedge clk) disable iff (!rst_n)
        do_rd && !do_wr |=> !full)
        else $error("fifo full after a lone read");

endmodule

>>> design/stlp_front.sv
// ----------------------------------------------------------------------------
// stlp_front : character classifier
// Turns one input request into a token: line end, or character class + digit.
// ----------------------------------------------------------------------------
module stlp_front (
    input  logic [7:0]      ch,
    input  logic            line_done,
    output stlp_pkg::token_t tok
);
    import stlp_pkg::*;

    char_class_t cls;

    always_comb
    begin
        priority if (ch >= CH_ZERO && ch <= CH_NINE)
            cls = CL_DIGIT;
        else if (ch == CH_COLON)
            cls = CL_COLON;
        else if (ch == CH_COMMA || ch == CH_DOT)
            cls = CL_SEP;
        else if (ch == CH_SPACE || ch == CH_TAB)
            cls = CL_BLANK;
        else if (ch == CH_DASH)
            cls = CL_DASH;
        else if (ch == CH_GT)
            cls = CL_GT;
        else if (ch == CH_CR || ch == CH_LF)
            cls = CL_BREAK;
        else
            cls = CL_OTHER;
    end

    // digit value is the low nibble of an ASCII digit
    assign tok.done  = line_done;
    assign tok.cls   = cls;
    assign tok.digit = ch[3:0];

endmodule

>>> design/stlp_back.sv
// ----------------------------------------------------------------------------
// stlp_back : line grammar engine
// Walks the grammar a token a cycle, line ends held on res_full; builds the times
// ----------------------------------------------------------------------------
module stlp_back #(
    parameter int MAX_HOURS = 99999
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  stlp_pkg::token_t  tok,
    output logic              tok_pop,
    input  logic              res_full,
    output logic              res_push,
    output stlp_pkg::result_t res
);
    import stlp_pkg::*;

    localparam longint unsigned ACC_CAP_V =
        (MAX_HOURS + 1 >= 1000) ? longint'(MAX_HOURS) + 1 : 1000;
    localparam int ACC_W = $clog2(ACC_CAP_V + 1);
    localparam longint unsigned MAX_TOTAL =
        (longint'(MAX_HOURS) + 1) * longint'(MS_PER_HOUR) - 1;
    localparam int TOT_W = $clog2(MAX_TOTAL + 1);
    localparam logic [ACC_W+3:0] ACC_CAP = (ACC_W + 4)'(ACC_CAP_V);

    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic               seen_reg, seen_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TOT_W-1:0]   first_reg, first_next;
    logic               broken_reg, broken_next;
    logic               trail_reg, trail_next;

    logic [ACC_W+3:0]   digit_sum;
    logic [ACC_W-1:0]   digit_accum;
    logic               limit_ok;
    logic               close_ok;
    logic [TOT_W-1:0]   close_total;
    logic               fin_broken;
    logic               fin_trail;
    logic [TOT_W-1:0]   fin_total;
    logic               fin_ok;

    // saturating decimal accumulate
    assign digit_sum   = (ACC_W + 4)'(accum_reg) * (ACC_W + 4)'(10)
                       + (ACC_W + 4)'(tok.digit);
    assign digit_accum = (digit_sum > ACC_CAP) ? ACC_CAP[ACC_W-1:0]
                                               : digit_sum[ACC_W-1:0];

    // field close: limit check and scaled add for the field the phase is in
    always_comb
    begin
        unique case (phase_reg)
            PH_H1, PH_H2:
            begin
                limit_ok    = (accum_reg <= ACC_W'(MAX_HOURS));
                close_ok    = seen_reg && limit_ok;
                close_total = TOT_W'(accum_reg) * TOT_W'(MS_PER_HOUR);
            end
            PH_M1, PH_M2:
            begin
                limit_ok    = (accum_reg < ACC_W'(MIN_LIMIT));
                close_ok    = seen_reg && limit_ok;
                close_total = total_reg + TOT_W'(accum_reg) * TOT_W'(MS_PER_MIN);
            end
            PH_S1, PH_S2:
            begin
                limit_ok    = (accum_reg < ACC_W'(MIN_LIMIT));
                close_ok    = seen_reg && limit_ok;
                close_total = total_reg + TOT_W'(accum_reg) * TOT_W'(MS_PER_SEC);
            end
            default:
            begin
                limit_ok    = (accum_reg < ACC_W'(MS_LIMIT));
                close_ok    = seen_reg && limit_ok;
                close_total = total_reg + TOT_W'(accum_reg);
            end
        endcase
    end

    // verdict at line end; an open millisecond field of the end stamp closes here
    assign fin_broken = broken_reg || ((phase_reg == PH_MS2) && !close_ok);
    assign fin_trail  = (phase_reg == PH_TRAIL) || (phase_reg == PH_MS2);
    assign fin_total  = (phase_reg == PH_MS2) ? close_total : total_reg;
    assign fin_ok     = !fin_broken && fin_trail && (fin_total > first_reg);

    assign tok_pop   = tok_valid && (!tok.done || !res_full);
    assign res_push  = tok_pop && tok.done;
    assign res.ok        = fin_ok;
    assign res.begin_ms  = fin_ok ? TIME_W'(first_reg) : '0;
    assign res.finish_ms = fin_ok ? TIME_W'(fin_total) : '0;

    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        seen_next   = seen_reg;
        total_next  = total_reg;
        first_next  = first_reg;
        broken_next = broken_reg;
        trail_next  = trail_reg;
        if (tok_pop && tok.done)
        begin
            phase_next  = PH_LEAD1;
            accum_next  = '0;
            seen_next   = 1'b0;
            total_next  = '0;
            first_next  = '0;
            broken_next = 1'b0;
            trail_next  = 1'b0;
        end
        else if (tok_pop)
        begin
            priority if (tok.cls == CL_BREAK)
            begin
                trail_next = 1'b1;
            end
            else if (trail_reg)
            begin
                broken_next = 1'b1;
            end
            else if (!broken_reg)
            begin
                unique case (phase_reg)
                    PH_LEAD1, PH_LEAD2:
                    begin
                        if (tok.cls == CL_DIGIT)
                        begin
                            phase_next = (phase_reg == PH_LEAD1) ? PH_H1 : PH_H2;
                            accum_next = digit_accum;
                            seen_next  = 1'b1;
                        end
                        else if (tok.cls != CL_BLANK)
                        begin
                            broken_next = 1'b1;
                        end
                    end
                    PH_GAP1:
                    begin
                        if (tok.cls == CL_DASH)
                            phase_next = PH_DASH1;
                        else if (tok.cls != CL_BLANK)
                            broken_next = 1'b1;
                    end
                    PH_DASH1:
                    begin
                        if (tok.cls == CL_DASH)
                            phase_next = PH_DASH2;
                        else
                            broken_next = 1'b1;
                    end
                    PH_DASH2:
                    begin
                        if (tok.cls == CL_GT)
                            phase_next = PH_LEAD2;
                        else
                            broken_next = 1'b1;
                    end
                    PH_TRAIL:
                    begin
                        if (tok.cls != CL_BLANK)
                            broken_next = 1'b1;
                    end
                    PH_H1, PH_M1, PH_S1, PH_MS1, PH_H2, PH_M2, PH_S2, PH_MS2:
                    begin
                        if (tok.cls == CL_DIGIT)
                        begin
                            accum_next = digit_accum;
                            seen_next  = 1'b1;
                        end
                        else if ((tok.cls == CL_COLON && (phase_reg == PH_H1
                                  || phase_reg == PH_M1 || phase_reg == PH_H2
                                  || phase_reg == PH_M2))
                              || (tok.cls == CL_SEP && (phase_reg == PH_S1
                                  || phase_reg == PH_S2))
                              || (phase_reg == PH_MS1 && (tok.cls == CL_BLANK
                                  || tok.cls == CL_DASH))
                              || (phase_reg == PH_MS2 && tok.cls == CL_BLANK))
                        begin
                            accum_next  = '0;
                            seen_next   = 1'b0;
                            broken_next = !close_ok;
                            if (close_ok)
                                total_next = close_total;
                            unique case (phase_reg)
                                PH_H1:   phase_next = PH_M1;
                                PH_M1:   phase_next = PH_S1;
                                PH_S1:   phase_next = PH_MS1;
                                PH_H2:   phase_next = PH_M2;
                                PH_M2:   phase_next = PH_S2;
                                PH_S2:   phase_next = PH_MS2;
                                PH_MS1:
                                begin
                                    first_next = close_total;
                                    total_next = '0;
                                    phase_next = (tok.cls == CL_DASH) ? PH_DASH1
                                                                      : PH_GAP1;
                                end
                                default: phase_next = PH_TRAIL;
                            endcase
                        end
                        else
                        begin
                            broken_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        broken_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD1;
            accum_reg  <= '0;
            seen_reg   <= 1'b0;
            total_reg  <= '0;
            first_reg  <= '0;
            broken_reg <= 1'b0;
            trail_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            seen_reg   <= seen_next;
            total_reg  <= total_next;
            first_reg  <= first_next;
            broken_reg <= broken_next;
            trail_reg  <= trail_next;
        end
    end

    a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop |-> tok_valid)
        else $error("token popped from an empty queue");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("verdict pushed into a full result queue");

    a_line_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (phase_reg == PH_LEAD1) && !broken_reg && !trail_reg && !seen_reg)
        else $error("parser state not cleared after line end");

endmodule

>>> design/srt_timing_line_parser_top.sv
// ----------------------------------------------------------------------------
// srt_timing_line_parser_top : subtitle timing line recogniser
// One request per cycle is taken while full is low; each is classified and queued.
// The grammar engine retires one queued request per cycle, holding a line-end
// request while the result queue is full; its verdict is then registered in the result
// queue and shows on the ports once every request queued ahead of it has retired.
// rst_n (async, active low) clears both queues and returns the parser to line start.
// ----------------------------------------------------------------------------
module srt_timing_line_parser_top #(
    parameter int MAX_HOURS = 99999
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request side
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       ch,
    input  logic                             line_done,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output logic                             timing_ok,
    output logic [stlp_pkg::TIME_W-1:0]      begin_time_ms,
    output logic [stlp_pkg::TIME_W-1:0]      finish_time_ms
);
    import stlp_pkg::*;

    localparam int TOK_W   = $bits(token_t);
    localparam int RES_W   = $bits(result_t);
    localparam int TOK_DEP = 4;   // absorbs short stalls of the result side
    localparam int RES_DEP = 2;   // lets a verdict wait while the next line streams in

    token_t             front_tok;
    token_t             back_tok;
    logic [TOK_W-1:0]   back_tok_bits;
    logic               tok_empty;
    logic               tok_pop;
    result_t            back_res;
    result_t            head_res;
    logic [RES_W-1:0]   head_res_bits;
    logic               res_full;
    logic               res_push;

    // Front: each request is reduced to a compact token (class + digit value)
    stlp_front u_front (
        .ch        (ch),
        .line_done (line_done),
        .tok       (front_tok)
    );

    // Token queue: decouples request intake from the grammar engine
    stlp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (TOK_DEP)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_tok),
        .full    (full),
        .rd_en   (tok_pop),
        .rd_data (back_tok_bits),
        .empty   (tok_empty)
    );

    assign back_tok = token_t'(back_tok_bits);

    // Back: grammar walk, field limits, time build-up; a line-end token only
    // retires when the result queue has room, characters always retire
    stlp_back #(
        .MAX_HOURS (MAX_HOURS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!tok_empty),
        .tok       (back_tok),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Result queue: the oldest verdict sits on the ports while empty is low
    stlp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEP)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (head_res_bits),
        .empty   (empty)
    );

    assign head_res       = result_t'(head_res_bits);
    assign timing_ok      = head_res.ok;
    assign begin_time_ms  = head_res.begin_ms;
    assign finish_time_ms = head_res.finish_ms;

endmodule
